// ===== hw/rtl/ssw_pkg.sv =====
// shared types, constants and the character-to-segment table for the display writer
`timescale 1ns / 1ps

package ssw_pkg;

	// request operations on the input channel
	typedef enum logic [1:0] {
		OP_PUT_CHAR     = 2'd0,
		OP_PRINT_NUMBER = 2'd1,
		OP_SET_DIGIT    = 2'd2,
		OP_CLEAR_ALL    = 2'd3
	} op_t;

	// command kinds handed from the front end to the back end
	typedef enum logic [1:0] {
		CMD_SINGLE = 2'd0,
		CMD_FILL   = 2'd1,
		CMD_NUMBER = 2'd2
	} cmd_kind_t;

	localparam int DIGIT_COUNT_DEFAULT = 4;
	localparam int POS_W               = 2;
	localparam int NUM_W               = 14;
	localparam int QUEUE_DEPTH         = 2;

	localparam logic [5:0] BASE_ADDRESS = 6'h34;
	localparam logic [7:0] DP_MASK      = 8'h80;
	localparam logic [6:0] CODE_CR      = 7'd13;
	localparam logic [6:0] CODE_BLANK   = 7'd32;
	localparam logic [6:0] CODE_ZERO    = 7'd48;
	localparam logic [6:0] CODE_E       = 7'd69;

	// divide by ten as multiply by ceil(2^16 / 10), exact for values below 10^4
	localparam int         RECIP_W   = 13;
	localparam logic [RECIP_W-1:0] RECIP_TEN = 13'd6554;
	localparam int         DIV_SHIFT = 16;

	// one queued command
	typedef struct packed {
		cmd_kind_t        kind;
		logic [POS_W-1:0] pos;
		logic [7:0]       seg;
		logic [NUM_W-1:0] value;
	} cmd_t;

	// segment patterns for codes 32 to 127
	localparam logic [7:0] GLYPHS [0:95] = '{
		8'h00, 8'h82, 8'h21, 8'h00, 8'h00, 8'h00, 8'h00, 8'h02,
		8'h39, 8'h0F, 8'h00, 8'h00, 8'h00, 8'h40, 8'h80, 8'h00,
		8'h3F, 8'h06, 8'h5B, 8'h4F, 8'h66, 8'h6D, 8'h7D, 8'h07,
		8'h7F, 8'h6F, 8'h00, 8'h00, 8'h00, 8'h48, 8'h00, 8'h53,
		8'h00, 8'h77, 8'h7C, 8'h39, 8'h5E, 8'h79, 8'h71, 8'h6F,
		8'h76, 8'h06, 8'h1E, 8'h00, 8'h38, 8'h00, 8'h54, 8'h3F,
		8'h73, 8'h67, 8'h50, 8'h6D, 8'h78, 8'h3E, 8'h00, 8'h00,
		8'h00, 8'h6E, 8'h00, 8'h39, 8'h00, 8'h0F, 8'h00, 8'h08,
		8'h63, 8'h5F, 8'h7C, 8'h58, 8'h5E, 8'h7B, 8'h71, 8'h6F,
		8'h74, 8'h02, 8'h1E, 8'h00, 8'h06, 8'h00, 8'h54, 8'h5C,
		8'h73, 8'h67, 8'h50, 8'h6D, 8'h78, 8'h1C, 8'h00, 8'h00,
		8'h00, 8'h6E, 8'h00, 8'h39, 8'h30, 8'h0F, 8'h00, 8'h00
	};

	// control codes show blank
	function automatic logic [7:0] seg_of(input logic [6:0] code);
		logic [6:0] idx;
		idx = code - CODE_BLANK;
		if (code < CODE_BLANK) begin
			return 8'h00;
		end
		return GLYPHS[idx];
	endfunction

	// ten to the power n, for elaboration-time limits
	function automatic int pow10(input int n);
		int acc;
		acc = 1;
		for (int i = 0; i < n; i++) begin
			acc = acc * 10;
		end
		return acc;
	endfunction

endpackage

// ===== hw/rtl/ssw_front.sv =====
// front end: takes requests, tracks the cursor, turns non-CR requests into commands
`timescale 1ns / 1ps

module ssw_front import ssw_pkg::*; #(
	parameter int DIGIT_COUNT = DIGIT_COUNT_DEFAULT
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [1:0]  operation,
	input  logic [6:0]  character,
	input  logic [15:0] number,
	input  logic [1:0]  digit_index,
	input  logic        decimal_point,
	output logic        push_valid,
	input  logic        push_ready,
	output cmd_t        push_cmd
);

	localparam int               LIMIT    = pow10(DIGIT_COUNT) - 1;
	localparam logic [POS_W-1:0] LAST_POS = POS_W'(DIGIT_COUNT - 1);

	op_t              op;
	logic             is_cr;
	logic             accept;
	logic [POS_W-1:0] cursor_q;

	assign op     = op_t'(operation);
	assign is_cr  = (op == OP_PUT_CHAR) && (character == CODE_CR);
	assign accept = in_valid && in_ready;

	// carriage return needs no queue slot but waits with the rest
	assign in_ready   = push_ready;
	assign push_valid = in_valid && !is_cr;

	// classify the request
	always_comb begin
		push_cmd.kind  = CMD_SINGLE;
		push_cmd.pos   = '0;
		push_cmd.seg   = '0;
		push_cmd.value = '0;
		case (op)
			OP_PUT_CHAR: begin
				push_cmd.pos = cursor_q;
				push_cmd.seg = seg_of(character);
			end
			OP_PRINT_NUMBER: begin
				if (number > 16'(LIMIT)) begin
					push_cmd.kind = CMD_FILL;
					push_cmd.seg  = seg_of(CODE_E);
				end else begin
					push_cmd.kind  = CMD_NUMBER;
					push_cmd.pos   = LAST_POS;
					push_cmd.value = number[NUM_W-1:0];
				end
			end
			OP_SET_DIGIT: begin
				push_cmd.pos = digit_index;
				push_cmd.seg = seg_of(character) ^ (decimal_point ? DP_MASK : 8'h00);
			end
			default: begin
				push_cmd.kind = CMD_FILL;
				push_cmd.seg  = seg_of(CODE_BLANK);
			end
		endcase
	end

	// wrapping cursor for put-char
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cursor_q <= '0;
		end else if (accept && op == OP_PUT_CHAR) begin
			if (is_cr || cursor_q == LAST_POS) begin
				cursor_q <= '0;
			end else begin
				cursor_q <= cursor_q + 1'b1;
			end
		end
	end

endmodule

// ===== hw/rtl/ssw_queue.sv =====
// short command queue between the front end and the back end
`timescale 1ns / 1ps

module ssw_queue import ssw_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic push_valid,
	output logic push_ready,
	input  cmd_t push_cmd,
	output logic pop_valid,
	input  logic pop_ready,
	output cmd_t pop_cmd
);

	localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
	localparam logic [PTR_W-1:0] LAST_SLOT = PTR_W'(QUEUE_DEPTH - 1);

	cmd_t             slots_q [QUEUE_DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             do_push;
	logic             do_pop;

	assign push_ready = count_q != CNT_W'(QUEUE_DEPTH);
	assign pop_valid  = count_q != '0;
	assign pop_cmd    = slots_q[rd_ptr_q];
	assign do_push    = push_valid && push_ready;
	assign do_pop     = pop_valid && pop_ready;

	// slot storage
	always_ff @(posedge clk) begin
		if (do_push) begin
			slots_q[wr_ptr_q] <= push_cmd;
		end
	end

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == LAST_SLOT) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == LAST_SLOT) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

// ===== hw/rtl/ssw_back.sv =====
// back end: expands commands into digit register writes, one per unstalled cycle
`timescale 1ns / 1ps

module ssw_back import ssw_pkg::*; #(
	parameter int DIGIT_COUNT = DIGIT_COUNT_DEFAULT
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       pop_valid,
	output logic       pop_ready,
	input  cmd_t       pop_cmd,
	output logic       out_valid,
	input  logic       out_ready,
	output logic [5:0] write_address,
	output logic [7:0] segment_byte,
	output logic       last_write
);

	localparam logic [POS_W-1:0] LAST_POS = POS_W'(DIGIT_COUNT - 1);

	logic                     busy_q;
	cmd_kind_t                kind_q;
	logic [POS_W-1:0]         pos_q;
	logic [7:0]               seg_q;
	logic [NUM_W-1:0]         rest_q;
	logic                     out_valid_q;

	logic                     advance;
	logic                     emit;
	logic                     step_last;
	logic [7:0]               step_seg;
	logic [NUM_W+RECIP_W-1:0] product;
	logic [NUM_W-1:0]         quotient;
	logic [NUM_W-1:0]         times_ten;
	logic [3:0]               remainder;
	logic                     blank;

	assign advance   = !out_valid_q || out_ready;
	assign emit      = busy_q && advance;
	assign pop_ready = !busy_q || (emit && step_last);
	assign out_valid = out_valid_q;

	// one decimal digit per step: rest / 10 by reciprocal, remainder by back-multiply
	assign product   = {{RECIP_W{1'b0}}, rest_q} * {{NUM_W{1'b0}}, RECIP_TEN};
	assign quotient  = NUM_W'(product >> DIV_SHIFT);
	assign times_ten = (quotient << 3) + (quotient << 1);
	assign remainder = 4'(rest_q - times_ten);
	assign blank     = (pos_q != LAST_POS) && (rest_q == '0);

	// segment byte and end-of-command flag for the current step
	always_comb begin
		step_seg  = seg_q;
		step_last = 1'b1;
		case (kind_q)
			CMD_SINGLE: begin
				step_last = 1'b1;
			end
			CMD_FILL: begin
				step_last = pos_q == LAST_POS;
			end
			CMD_NUMBER: begin
				step_seg  = blank ? seg_of(CODE_BLANK) : seg_of(CODE_ZERO + {3'b000, remainder});
				step_last = pos_q == '0;
			end
			default: begin
				step_last = 1'b1;
			end
		endcase
	end

	// command sequencing
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (pop_valid && pop_ready) begin
				busy_q <= 1'b1;
			end else if (emit && step_last) begin
				busy_q <= 1'b0;
			end
			if (emit) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// command payload and step position
	always_ff @(posedge clk) begin
		if (pop_valid && pop_ready) begin
			kind_q <= pop_cmd.kind;
			pos_q  <= pop_cmd.pos;
			seg_q  <= pop_cmd.seg;
			rest_q <= pop_cmd.value;
		end else if (emit) begin
			if (kind_q == CMD_FILL) begin
				pos_q <= pos_q + 1'b1;
			end else if (kind_q == CMD_NUMBER) begin
				pos_q  <= pos_q - 1'b1;
				rest_q <= quotient;
			end
		end
	end

	// output register
	always_ff @(posedge clk) begin
		if (emit) begin
			write_address <= BASE_ADDRESS + {{(6-POS_W){1'b0}}, pos_q};
			segment_byte  <= step_seg;
			last_write    <= step_last;
		end
	end

endmodule

// ===== hw/rtl/seven_segment_text_number_writer.sv =====
// top level of the seven-segment text and number writer
`timescale 1ns / 1ps

// Turns display requests (put character at a wrapping cursor, print a decimal number with
// leading-zero blanking, set one digit with optional decimal point, clear all) into digit
// register writes at address 0x34 plus position. The output channel carries one write per
// cycle unless out_ready is low: put-char and set-digit give one write, print-number and
// clear give DIGIT_COUNT writes, a carriage return gives none and only homes the cursor.
// A request occupies the back end for one step per write; print-number pulls one decimal
// digit per cycle, unless the output stalls, from a single multiply-by-reciprocal unit,
// which paces it. A two-entry command queue takes new requests while earlier ones drain;
// a request on a free back end passes its queue slot, command and output registers.
module seven_segment_text_number_writer import ssw_pkg::*; #(
	parameter int DIGIT_COUNT = DIGIT_COUNT_DEFAULT
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [1:0]  operation,
	input  logic [6:0]  character,
	input  logic [15:0] number,
	input  logic [1:0]  digit_index,
	input  logic        decimal_point,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [5:0]  write_address,
	output logic [7:0]  segment_byte,
	output logic        last_write
);

	localparam int LIMIT = pow10(DIGIT_COUNT) - 1;

	logic push_valid;
	logic push_ready;
	cmd_t push_cmd;
	logic pop_valid;
	logic pop_ready;
	cmd_t pop_cmd;

	ssw_front #(
		.DIGIT_COUNT(DIGIT_COUNT)
	) u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.operation    (operation),
		.character    (character),
		.number       (number),
		.digit_index  (digit_index),
		.decimal_point(decimal_point),
		.push_valid   (push_valid),
		.push_ready   (push_ready),
		.push_cmd     (push_cmd)
	);

	ssw_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push_valid(push_valid),
		.push_ready(push_ready),
		.push_cmd  (push_cmd),
		.pop_valid (pop_valid),
		.pop_ready (pop_ready),
		.pop_cmd   (pop_cmd)
	);

	ssw_back #(
		.DIGIT_COUNT(DIGIT_COUNT)
	) u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.pop_valid    (pop_valid),
		.pop_ready    (pop_ready),
		.pop_cmd      (pop_cmd),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.write_address(write_address),
		.segment_byte (segment_byte),
		.last_write   (last_write)
	);

	// a burst of writes for one request has no gaps once it is being taken
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_ready && !last_write |=> out_valid)
		else $error("gap inside a multi-write burst");

	// numbers reaching the back end were range checked by the front end
	assert property (@(posedge clk) disable iff (!arst_n)
		pop_valid && pop_cmd.kind == CMD_NUMBER |-> 32'(pop_cmd.value) <= LIMIT)
		else $error("queued number above display range");

	// every write lands in the digit register window
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> write_address[5:2] == BASE_ADDRESS[5:2])
		else $error("write address outside digit registers");

endmodule

// ===== tb/sv/tb.sv =====
// self-checking testbench for the seven-segment text and number writer
`timescale 1ns / 1ps

module tb;
	import ssw_pkg::*;

	localparam int DIGITS      = 4;
	localparam int NUMBER_MAX  = 9999;
	localparam int HOLD_CYCLES = 120;
	localparam int IDLE_LIMIT  = 2000;
	localparam int SETTLE      = 16;

	// segment patterns for codes 32 to 127, bit 7 is the decimal point
	localparam logic [7:0] CHAR_SEGMENTS [0:95] = '{
		8'h00, 8'h82, 8'h21, 8'h00, 8'h00, 8'h00, 8'h00, 8'h02,
		8'h39, 8'h0F, 8'h00, 8'h00, 8'h00, 8'h40, 8'h80, 8'h00,
		8'h3F, 8'h06, 8'h5B, 8'h4F, 8'h66, 8'h6D, 8'h7D, 8'h07,
		8'h7F, 8'h6F, 8'h00, 8'h00, 8'h00, 8'h48, 8'h00, 8'h53,
		8'h00, 8'h77, 8'h7C, 8'h39, 8'h5E, 8'h79, 8'h71, 8'h6F,
		8'h76, 8'h06, 8'h1E, 8'h00, 8'h38, 8'h00, 8'h54, 8'h3F,
		8'h73, 8'h67, 8'h50, 8'h6D, 8'h78, 8'h3E, 8'h00, 8'h00,
		8'h00, 8'h6E, 8'h00, 8'h39, 8'h00, 8'h0F, 8'h00, 8'h08,
		8'h63, 8'h5F, 8'h7C, 8'h58, 8'h5E, 8'h7B, 8'h71, 8'h6F,
		8'h74, 8'h02, 8'h1E, 8'h00, 8'h06, 8'h00, 8'h54, 8'h5C,
		8'h73, 8'h67, 8'h50, 8'h6D, 8'h78, 8'h1C, 8'h00, 8'h00,
		8'h00, 8'h6E, 8'h00, 8'h39, 8'h30, 8'h0F, 8'h00, 8'h00
	};

	// one digit register write as seen on the result channel
	typedef struct {
		logic [5:0] address;
		logic [7:0] segments;
		logic       is_last;
	} digit_write_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_ready;
	logic [1:0]  operation = 2'd0;
	logic [6:0]  character = 7'd0;
	logic [15:0] number = 16'd0;
	logic [1:0]  digit_index = 2'd0;
	logic        decimal_point = 1'b0;
	logic        out_valid;
	logic        out_ready = 1'b0;
	logic [5:0]  write_address;
	logic [7:0]  segment_byte;
	logic        last_write;

	digit_write_t pending_writes [$];
	logic [1:0]   display_cursor = 2'd0;
	bit           gaps_on = 1'b1;
	bit           hold_request = 1'b0;
	int           mismatch_count = 0;
	int           writes_checked = 0;
	int           op_count [4] = '{0, 0, 0, 0};
	int           cr_count = 0;
	int           overflow_count = 0;
	int           idle_cycles = 0;

	seven_segment_text_number_writer #(
		.DIGIT_COUNT(DIGITS)
	) dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.operation    (operation),
		.character    (character),
		.number       (number),
		.digit_index  (digit_index),
		.decimal_point(decimal_point),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.write_address(write_address),
		.segment_byte (segment_byte),
		.last_write   (last_write)
	);

	// 10 ns clock
	initial begin
		forever begin
			#5 clk = ~clk;
		end
	end

	// segment pattern of one code, control codes show blank
	function automatic logic [7:0] segments_for(input logic [6:0] code);
		if (code < CODE_BLANK) begin
			return 8'h00;
		end
		return CHAR_SEGMENTS[code - CODE_BLANK];
	endfunction

	function automatic void push_write(input int pos, input logic [7:0] seg, input bit is_last);
		digit_write_t w;
		w.address  = BASE_ADDRESS + 6'(pos);
		w.segments = seg;
		w.is_last  = is_last;
		pending_writes.push_back(w);
	endfunction

	// works out the register writes of one accepted request and updates the cursor
	function automatic void predict_writes(input op_t op, input logic [6:0] ch,
			input logic [15:0] num, input logic [1:0] idx, input logic dp);
		int rest;
		logic [7:0] seg;
		op_count[op]++;
		case (op)
			OP_PUT_CHAR: begin
				// carriage return homes the cursor without a write
				if (ch == CODE_CR) begin
					display_cursor = 2'd0;
					cr_count++;
				end else begin
					push_write(display_cursor, segments_for(ch), 1'b1);
					display_cursor = (display_cursor == DIGITS - 1) ? 2'd0 : display_cursor + 2'd1;
				end
			end
			OP_PRINT_NUMBER: begin
				if (num > NUMBER_MAX) begin
					overflow_count++;
					for (int p = 0; p < DIGITS; p++) begin
						push_write(p, segments_for(CODE_E), p == DIGITS - 1);
					end
				end else begin
					// ones digit first, leading zeros blanked
					rest = num;
					for (int p = DIGITS - 1; p >= 0; p--) begin
						if (p != DIGITS - 1 && rest == 0) begin
							seg = segments_for(CODE_BLANK);
						end else begin
							seg = segments_for(CODE_ZERO + 7'(rest % 10));
						end
						push_write(p, seg, p == 0);
						rest = rest / 10;
					end
				end
			end
			OP_SET_DIGIT: begin
				// the decimal point is added, so a glyph that already has bit 7 loses it
				seg = segments_for(ch);
				if (dp) begin
					seg = seg + DP_MASK;
				end
				push_write(idx, seg, 1'b1);
			end
			default: begin
				for (int p = 0; p < DIGITS; p++) begin
					push_write(p, segments_for(CODE_BLANK), p == DIGITS - 1);
				end
			end
		endcase
	endfunction

	function automatic int random_gap_len();
		if ($urandom_range(0, 99) < 85) begin
			return $urandom_range(1, 3);
		end
		return $urandom_range(4, 30);
	endfunction

	function automatic int sender_gap();
		if (!gaps_on || $urandom_range(0, 1) == 0) begin
			return 0;
		end
		return random_gap_len();
	endfunction

	function automatic logic [6:0] random_char();
		int r;
		r = $urandom_range(0, 19);
		if (r < 2) begin
			return CODE_CR;
		end
		if (r < 4) begin
			return 7'($urandom_range(0, 31));
		end
		return 7'($urandom_range(0, 127));
	endfunction

	// spread numbers over every digit count, the overflow edge and the full range
	function automatic logic [15:0] random_number();
		case ($urandom_range(0, 9))
			0: return 16'($urandom_range(0, 9));
			1: return 16'($urandom_range(10, 99));
			2: return 16'($urandom_range(100, 999));
			3, 4, 5: return 16'($urandom_range(1000, NUMBER_MAX));
			6: return 16'($urandom_range(NUMBER_MAX - 1, NUMBER_MAX + 2));
			default: return 16'($urandom_range(0, 65535));
		endcase
	endfunction

	task automatic report_mismatch(input string what);
		mismatch_count++;
		if (mismatch_count <= 50) begin
			$display("mismatch at %0t ns: %s", $time, what);
		end
	endtask

	// offers one request and waits for its transfer, called at a rising edge
	task automatic send_request(input op_t op, input logic [6:0] ch, input logic [15:0] num,
			input logic [1:0] idx, input logic dp);
		int gap;
		gap = sender_gap();
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid      <= 1'b1;
		operation     <= op;
		character     <= ch;
		number        <= num;
		digit_index   <= idx;
		decimal_point <= dp;
		@(posedge clk);
		while (!in_ready) begin
			@(posedge clk);
		end
		predict_writes(op, ch, num, idx, dp);
	endtask

	// sender goes quiet until every expected write has come out
	task automatic wait_drained();
		in_valid <= 1'b0;
		do begin
			@(posedge clk);
		end while (pending_writes.size() != 0);
	endtask

	task automatic test_put_char();
		send_request(OP_PUT_CHAR, 7'd72, 16'($urandom), 2'($urandom), 1'($urandom));
		send_request(OP_PUT_CHAR, 7'd0, 16'($urandom), 2'($urandom), 1'($urandom));
		send_request(OP_PUT_CHAR, CODE_CR, 16'($urandom), 2'($urandom), 1'($urandom));
		send_request(OP_PUT_CHAR, 7'd127, 16'($urandom), 2'($urandom), 1'($urandom));
		send_request(OP_PUT_CHAR, 7'd57, 16'($urandom), 2'($urandom), 1'($urandom));
		send_request(OP_PUT_CHAR, CODE_BLANK, 16'($urandom), 2'($urandom), 1'($urandom));
		send_request(OP_PUT_CHAR, 7'd31, 16'($urandom), 2'($urandom), 1'($urandom));
		// cursor wraps back to the first digit here
		send_request(OP_PUT_CHAR, 7'd65, 16'($urandom), 2'($urandom), 1'($urandom));
	endtask

	task automatic test_print_number();
		send_request(OP_PRINT_NUMBER, 7'($urandom), 16'd0, 2'($urandom), 1'($urandom));
		send_request(OP_PRINT_NUMBER, 7'($urandom), 16'd7, 2'($urandom), 1'($urandom));
		send_request(OP_PRINT_NUMBER, 7'($urandom), 16'd100, 2'($urandom), 1'($urandom));
		send_request(OP_PRINT_NUMBER, 7'($urandom), 16'd1234, 2'($urandom), 1'($urandom));
		send_request(OP_PRINT_NUMBER, 7'($urandom), 16'd9999, 2'($urandom), 1'($urandom));
		send_request(OP_PRINT_NUMBER, 7'($urandom), 16'd10000, 2'($urandom), 1'($urandom));
		send_request(OP_PRINT_NUMBER, 7'($urandom), 16'hFFFF, 2'($urandom), 1'($urandom));
	endtask

	task automatic test_set_digit();
		send_request(OP_SET_DIGIT, 7'd48, 16'($urandom), 2'd0, 1'b0);
		send_request(OP_SET_DIGIT, 7'd56, 16'($urandom), 2'd3, 1'b1);
		// glyphs that already light the point wrap it off again
		send_request(OP_SET_DIGIT, 7'd33, 16'($urandom), 2'd1, 1'b1);
		send_request(OP_SET_DIGIT, 7'd46, 16'($urandom), 2'd2, 1'b1);
		send_request(OP_SET_DIGIT, CODE_CR, 16'($urandom), 2'd3, 1'b1);
	endtask

	task automatic test_clear_all();
		send_request(OP_PUT_CHAR, 7'd99, 16'($urandom), 2'($urandom), 1'($urandom));
		send_request(OP_CLEAR_ALL, 7'($urandom), 16'($urandom), 2'($urandom), 1'($urandom));
		send_request(OP_PUT_CHAR, 7'd100, 16'($urandom), 2'($urandom), 1'($urandom));
	endtask

	task automatic test_random_mix(input int count);
		for (int k = 0; k < count; k++) begin
			// some stretches run back to back with no sender gaps
			if (k % 50 == 0) begin
				gaps_on = ($urandom_range(0, 3) != 0);
			end
			send_request(op_t'($urandom_range(0, 3)), random_char(), random_number(),
				2'($urandom), 1'($urandom));
		end
		gaps_on = 1'b1;
	endtask

	// receiver holds off long enough for the block to fill and stall its input
	task automatic test_backpressure(input int count);
		gaps_on = 1'b0;
		hold_request = 1'b1;
		for (int k = 0; k < count; k++) begin
			send_request(op_t'($urandom_range(0, 3)), random_char(), random_number(),
				2'($urandom), 1'($urandom));
		end
		gaps_on = 1'b1;
	endtask

	task automatic test_drain_pause(input int rounds);
		for (int r = 0; r < rounds; r++) begin
			for (int k = 0; k < 6; k++) begin
				send_request(op_t'($urandom_range(0, 3)), random_char(), random_number(),
					2'($urandom), 1'($urandom));
			end
			wait_drained();
		end
	endtask

	// result sink: random stalls, steady stretches and the long hold-off on request
	initial begin : result_sink
		int stall_left;
		int hold_left;
		int span;
		bit steady;
		stall_left = 0;
		hold_left  = 0;
		span       = 0;
		steady     = 1'b0;
		forever begin
			@(posedge clk);
			if (span == 0) begin
				span   = 64;
				steady = ($urandom_range(0, 3) == 0);
			end
			span--;
			if (hold_request) begin
				hold_request = 1'b0;
				hold_left    = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				hold_left--;
				out_ready <= 1'b0;
			end else if (stall_left > 0) begin
				stall_left--;
				out_ready <= 1'b0;
			end else if (!steady && $urandom_range(0, 3) == 0) begin
				stall_left = random_gap_len() - 1;
				out_ready <= 1'b0;
			end else begin
				out_ready <= 1'b1;
			end
		end
	end

	// compare each write transfer with the oldest expected write
	always @(posedge clk) begin : write_checker
		digit_write_t want;
		if (arst_n && out_valid && out_ready) begin
			writes_checked++;
			if (pending_writes.size() == 0) begin
				report_mismatch($sformatf("unexpected write addr %h seg %h last %b",
					write_address, segment_byte, last_write));
			end else begin
				want = pending_writes.pop_front();
				if (write_address !== want.address) begin
					report_mismatch($sformatf("write_address %h, wanted %h",
						write_address, want.address));
				end
				if (segment_byte !== want.segments) begin
					report_mismatch($sformatf("segment_byte %h, wanted %h at addr %h",
						segment_byte, want.segments, want.address));
				end
				if (last_write !== want.is_last) begin
					report_mismatch($sformatf("last_write %b, wanted %b at addr %h",
						last_write, want.is_last, want.address));
				end
			end
		end
	end

	// watchdog on cycles with no transfer on either channel
	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && in_ready) || (out_valid && out_ready)) begin
				idle_cycles <= 0;
			end else begin
				idle_cycles <= idle_cycles + 1;
			end
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("timeout: no transfer for %0d cycles, %0d writes outstanding",
					idle_cycles, pending_writes.size());
				$display("end of test: mismatches");
				$finish;
			end
		end
	end

	initial begin : run
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_put_char();
		test_print_number();
		test_set_digit();
		test_clear_all();
		test_random_mix(410);
		test_backpressure(24);
		test_drain_pause(3);
		wait_drained();
		repeat (SETTLE) @(posedge clk);
		$display("covered %0d put, %0d print, %0d set, %0d clear requests", op_count[OP_PUT_CHAR],
			op_count[OP_PRINT_NUMBER], op_count[OP_SET_DIGIT], op_count[OP_CLEAR_ALL]);
		$display("%0d carriage returns, %0d overflowed numbers, %0d writes compared, %0d errors",
			cr_count, overflow_count, writes_checked, mismatch_count);
		if (mismatch_count == 0) begin
			$display("end of test: clean");
		end else begin
			$display("end of test: mismatches");
		end
		$finish;
	end

endmodule

// ===== filelist.f =====
hw/rtl/ssw_pkg.sv
hw/rtl/ssw_front.sv
hw/rtl/ssw_queue.sv
hw/rtl/ssw_back.sv
hw/rtl/seven_segment_text_number_writer.sv
tb/sv/tb.sv
